// ===== hdl/layer_color_correct_rgb565_assert.svh =====
// Assertion macros for the layer color corrector.
// Used by the top level only; no other dependencies.
`ifndef LAYER_COLOR_CORRECT_RGB565_ASSERT_SVH
`define LAYER_COLOR_CORRECT_RGB565_ASSERT_SVH

// same-cycle implication, off during reset
`define LCC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define LCC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always checked (reset behavior)
`define LCC_ASSERT_ALW(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lcc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the color corrector.
// No dependencies; imported by every module of the block.
package lcc_pkg;

    typedef logic [7:0]     lcc_chan_t;
    typedef lcc_chan_t [2:0] lcc_rgb_t;   // [0] red, [1] green, [2] blue

    typedef enum logic {
        LCC_OP_COMPOSITE = 1'b0,
        LCC_OP_DIRECT    = 1'b1
    } lcc_op_t;

    // register write indexes
    typedef enum logic [2:0] {
        REG_TRANSPARENT_COLOR = 3'd0,
        REG_COLOR_BRIGHTNESS  = 3'd1,
        REG_TOP_BRIGHTNESS    = 3'd2,
        REG_TOP_SATURATION    = 3'd3,
        REG_BOTTOM_BRIGHTNESS = 3'd4,
        REG_BOTTOM_BLACK_CUT  = 3'd5,
        REG_TONE_STRENGTH     = 3'd6,
        REG_TONE_BLACK_CUT    = 3'd7
    } lcc_reg_t;

    typedef struct packed {
        logic valid;
        logic fg;
    } lcc_ctl_t;

    typedef struct packed {
        logic [23:0] transparent_color;
        logic [7:0]  color_brightness;
        logic [7:0]  top_brightness;
        logic [8:0]  top_saturation;
        logic [7:0]  bottom_brightness;
        logic [7:0]  bottom_black_cut;
        logic [7:0]  tone_strength;
        logic [7:0]  tone_black_cut;
    } lcc_cfg_t;

    typedef struct packed {
        logic        fg;
        logic [15:0] pixel;
    } lcc_out_t;

    localparam logic [7:0]  LCC_LUMA_R    = 8'd77;
    localparam logic [7:0]  LCC_LUMA_G    = 8'd150;
    localparam logic [7:0]  LCC_LUMA_B    = 8'd29;
    localparam logic [7:0]  LCC_FULL      = 8'd255;
    localparam logic [7:0]  LCC_HALF_RND  = 8'd127;
    localparam logic [8:0]  LCC_SAT_UNITY = 9'd128;
    localparam logic [8:0]  LCC_FG_SAT    = 9'd190;
    localparam logic [7:0]  LCC_FG_GAIN   = 8'd170;
    localparam logic [7:0]  LCC_FG_RND    = 8'd64;

    // (77r + 150g + 29b) >> 8
    function automatic lcc_chan_t lcc_luma(input lcc_rgb_t c);
        logic [15:0] sum;
        sum = 16'(c[0]) * 16'(LCC_LUMA_R) + 16'(c[1]) * 16'(LCC_LUMA_G)
            + 16'(c[2]) * 16'(LCC_LUMA_B);
        return sum[15:8];
    endfunction

    // x / 255, exact for x below 65280
    function automatic lcc_chan_t lcc_div255(input logic [16:0] x);
        logic [16:0] t;
        t = x + (x >> 8) + 17'd1;
        return t[15:8];
    endfunction

    // (v - luma) * sat
    function automatic logic signed [18:0] lcc_sat_prod(input lcc_chan_t v,
                                                         input lcc_chan_t luma,
                                                         input logic [8:0] sat);
        logic signed [8:0]  d;
        logic signed [18:0] dx;
        logic signed [18:0] sx;
        d  = $signed({1'b0, v}) - $signed({1'b0, luma});
        dx = 19'(d);
        sx = $signed({10'b0, sat});
        return dx * sx;
    endfunction

    // luma + p/128 (toward zero), clamped to 0..255
    function automatic lcc_chan_t lcc_sat_finish(input logic signed [18:0] p,
                                                 input lcc_chan_t luma);
        logic signed [18:0] adj;
        logic signed [18:0] q;
        logic signed [11:0] s;
        adj = p + (p[18] ? 19'sd127 : 19'sd0);
        q   = adj >>> 7;
        s   = $signed(q[11:0]) + $signed({4'b0, luma});
        if (s[11]) begin
            return 8'd0;
        end else if (s > 12'sd255) begin
            return LCC_FULL;
        end
        return s[7:0];
    endfunction

endpackage

// ===== hdl/layer_color_correct_rgb565.sv =====
// Two-layer color corrector, RGB888 in, RGB565 out; uses lcc_pkg, lcc_prep,
// lcc_tft_fg, lcc_tft_bg and layer_color_correct_rgb565_assert.svh.
// From input transfer to m_tvalid: six profile stages, five panel stages and
// one output register. Throughput: one pixel per clock unless the output stalls.
// Reset (aresetn low, synchronous): pipeline and output empty, registers
// back to their default values; s_tready is high right after reset.
`include "layer_color_correct_rgb565_assert.svh"

module layer_color_correct_rgb565 (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // top_red, top_green, top_blue,
                                   // bottom_red, bottom_green, bottom_blue
    input  logic [1:0]  s_tuser,   // opcode, use_foreground_profile
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pixel_rgb565
    output logic        m_tuser,   // used_top_profile
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import lcc_pkg::*;

    lcc_cfg_t cfg_reg;

    // Register writes are always taken; they must only happen while the block is idle (user's duty, not enforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.transparent_color <= 24'h000000;
            cfg_reg.color_brightness  <= 8'd255;
            cfg_reg.top_brightness    <= 8'd235;
            cfg_reg.top_saturation    <= 9'd160;
            cfg_reg.bottom_brightness <= 8'd44;
            cfg_reg.bottom_black_cut  <= 8'd9;
            cfg_reg.tone_strength     <= 8'd220;
            cfg_reg.tone_black_cut    <= 8'd4;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TRANSPARENT_COLOR: cfg_reg.transparent_color <= cfg_data;
                REG_COLOR_BRIGHTNESS:  cfg_reg.color_brightness  <= cfg_data[7:0];
                REG_TOP_BRIGHTNESS:    cfg_reg.top_brightness    <= cfg_data[7:0];
                REG_TOP_SATURATION:    cfg_reg.top_saturation    <= cfg_data[8:0];
                REG_BOTTOM_BRIGHTNESS: cfg_reg.bottom_brightness <= cfg_data[7:0];
                REG_BOTTOM_BLACK_CUT:  cfg_reg.bottom_black_cut  <= cfg_data[7:0];
                REG_TONE_STRENGTH:     cfg_reg.tone_strength     <= cfg_data[7:0];
                REG_TONE_BLACK_CUT:    cfg_reg.tone_black_cut    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together while the skid register is empty.
    // An output stall parks the next valid pixel in the skid register, and
    // s_tready stays low, stopping input transfers, while that register is full.
    logic     en;
    logic     skid_valid_reg;
    lcc_out_t skid_data_reg;
    logic     out_valid_reg;
    lcc_out_t out_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    lcc_rgb_t in_top, in_bottom;
    assign in_top    = {s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]};
    assign in_bottom = {s_tdata[47:40], s_tdata[39:32], s_tdata[31:24]};

    // display profile
    lcc_ctl_t prep_ctl;
    lcc_rgb_t prep_color;

    lcc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser[0]),
        .in_use_fg (s_tuser[1]),
        .in_top    (in_top),
        .in_bottom (in_bottom),
        .cfg       (cfg_reg),
        .out_ctl   (prep_ctl),
        .out_color (prep_color)
    );

    // both panel stages run on every pixel; the profile flag picks one at the end
    lcc_ctl_t fin_ctl;
    lcc_rgb_t fg_color;
    lcc_rgb_t bg_color;

    lcc_tft_fg u_tft_fg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_ctl    (prep_ctl),
        .in_color  (prep_color),
        .out_ctl   (fin_ctl),
        .out_color (fg_color)
    );

    lcc_tft_bg u_tft_bg (
        .aclk      (aclk),
        .en        (en),
        .in_color  (prep_color),
        .cfg       (cfg_reg),
        .out_color (bg_color)
    );

    // 5-6-5 packing, red in the top bits
    lcc_rgb_t fin_color;
    lcc_out_t fin_item;

    always_comb begin
        fin_color      = fin_ctl.fg ? fg_color : bg_color;
        fin_item.fg    = fin_ctl.fg;
        fin_item.pixel = {fin_color[0][7:3], fin_color[1][7:2], fin_color[2][7:3]};
    end

    // output register plus skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= fin_ctl.valid;
            out_data_reg  <= fin_item;
        end else if (fin_ctl.valid) begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= fin_item;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg.pixel;
    assign m_tuser  = out_data_reg.fg;

    // checks
    `LCC_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg,
                    "skid holds a pixel with the output register empty")
    `LCC_ASSERT_NXT(a_skid_holds, aclk, aresetn, skid_valid_reg && !m_tready,
                    skid_valid_reg && $stable(skid_data_reg),
                    "parked pixel lost during output stall")
    `LCC_ASSERT_NXT(a_pipe_frozen, aclk, aresetn, fin_ctl.valid && skid_valid_reg,
                    fin_ctl.valid, "pipeline pixel dropped while skid is full")
    `LCC_ASSERT_ALW(a_reset_flush, aclk, !aresetn, !out_valid_reg && !skid_valid_reg,
                    "output not empty after reset")

endmodule

// ===== hdl/lcc_prep.sv =====
// Display profile pipeline: source select, luma saturation, scaling, black cut.
// Six register stages; depends on lcc_pkg.
module lcc_prep (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic              in_opcode,
    input  logic              in_use_fg,
    input  lcc_pkg::lcc_rgb_t in_top,
    input  lcc_pkg::lcc_rgb_t in_bottom,
    input  lcc_pkg::lcc_cfg_t cfg,
    output lcc_pkg::lcc_ctl_t out_ctl,
    output lcc_pkg::lcc_rgb_t out_color
);
    import lcc_pkg::*;

    lcc_ctl_t ctl_reg [6];

    // stage 1: select
    logic       direct;
    logic       fg_sel;
    lcc_rgb_t   c1_next, c1_reg;
    logic [8:0] sat1_next, sat1_reg;
    lcc_chan_t  k1_next, k1_reg;
    logic       cut1_next, cut1_reg;

    always_comb begin
        direct    = (in_opcode == LCC_OP_DIRECT);
        fg_sel    = direct ? in_use_fg
                           : ({in_top[0], in_top[1], in_top[2]} != cfg.transparent_color);
        c1_next   = (!direct && !fg_sel) ? in_bottom : in_top;
        sat1_next = (!direct && fg_sel) ? cfg.top_saturation : LCC_SAT_UNITY;
        k1_next   = direct ? cfg.color_brightness
                           : (fg_sel ? cfg.top_brightness : cfg.bottom_brightness);
        cut1_next = !direct && !fg_sel;
    end

    // stage 2: luma
    lcc_rgb_t   c2_reg;
    lcc_chan_t  luma2_reg;
    logic [8:0] sat2_reg;
    lcc_chan_t  k2_reg;
    logic       cut2_reg;

    // stage 3: saturation products
    logic signed [18:0] prod3_next [3];
    logic signed [18:0] prod3_reg  [3];
    lcc_chan_t          luma3_reg;
    lcc_chan_t          k3_reg;
    logic               cut3_reg;

    // stage 4: saturation result
    lcc_rgb_t  c4_next, c4_reg;
    lcc_chan_t k4_reg;
    logic      cut4_reg;

    // stage 5: brightness product
    logic [16:0] sk5_next [3];
    logic [16:0] sk5_reg  [3];
    logic        cut5_reg;

    // stage 6: divide and black cut
    lcc_rgb_t  c6_next, c6_reg;
    lcc_chan_t max6;
    lcc_rgb_t  sc6;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod3_next[i] = lcc_sat_prod(c2_reg[i], luma2_reg, sat2_reg);
            c4_next[i]    = lcc_sat_finish(prod3_reg[i], luma3_reg);
            sk5_next[i]   = 17'(c4_reg[i]) * 17'(k4_reg) + 17'(LCC_HALF_RND);
            sc6[i]        = lcc_div255(sk5_reg[i]);
        end
        max6 = sc6[0];
        if (sc6[1] > max6) max6 = sc6[1];
        if (sc6[2] > max6) max6 = sc6[2];
        c6_next = sc6;
        if (cut5_reg && (cfg.bottom_black_cut != 8'd0) && (max6 < cfg.bottom_black_cut)) begin
            c6_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) ctl_reg[i] <= '0;
        end else if (en) begin
            ctl_reg[0] <= '{valid: in_valid, fg: fg_sel};
            for (int i = 1; i < 6; i++) ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg    <= c1_next;
            sat1_reg  <= sat1_next;
            k1_reg    <= k1_next;
            cut1_reg  <= cut1_next;
            c2_reg    <= c1_reg;
            luma2_reg <= lcc_luma(c1_reg);
            sat2_reg  <= sat1_reg;
            k2_reg    <= k1_reg;
            cut2_reg  <= cut1_reg;
            prod3_reg <= prod3_next;
            luma3_reg <= luma2_reg;
            k3_reg    <= k2_reg;
            cut3_reg  <= cut2_reg;
            c4_reg    <= c4_next;
            k4_reg    <= k3_reg;
            cut4_reg  <= cut3_reg;
            sk5_reg   <= sk5_next;
            cut5_reg  <= cut4_reg;
            c6_reg    <= c6_next;
        end
    end

    assign out_ctl   = ctl_reg[5];
    assign out_color = c6_reg;

endmodule

// ===== hdl/lcc_tft_fg.sv =====
// Foreground panel stage: saturation 190/128 around luma, then gain 170/128.
// Five register stages carrying the control word; depends on lcc_pkg.
module lcc_tft_fg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  lcc_pkg::lcc_ctl_t in_ctl,
    input  lcc_pkg::lcc_rgb_t in_color,
    output lcc_pkg::lcc_ctl_t out_ctl,
    output lcc_pkg::lcc_rgb_t out_color
);
    import lcc_pkg::*;

    // black needs no bypass: every step maps zero to zero
    lcc_ctl_t ctl_reg [5];

    lcc_rgb_t           c1_reg;
    lcc_chan_t          luma1_reg;
    logic signed [18:0] prod2_next [3];
    logic signed [18:0] prod2_reg  [3];
    lcc_chan_t          luma2_reg;
    lcc_rgb_t           c3_next, c3_reg;
    logic [15:0]        gain4_next [3];
    logic [15:0]        gain4_reg  [3];
    lcc_rgb_t           c5_next, c5_reg;
    logic [8:0]         g5 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod2_next[i] = lcc_sat_prod(c1_reg[i], luma1_reg, LCC_FG_SAT);
            c3_next[i]    = lcc_sat_finish(prod2_reg[i], luma2_reg);
            gain4_next[i] = 16'(c3_reg[i]) * 16'(LCC_FG_GAIN) + 16'(LCC_FG_RND);
            g5[i]         = gain4_reg[i][15:7];
            c5_next[i]    = g5[i][8] ? LCC_FULL : g5[i][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) ctl_reg[i] <= '0;
        end else if (en) begin
            ctl_reg[0] <= in_ctl;
            for (int i = 1; i < 5; i++) ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg    <= in_color;
            luma1_reg <= lcc_luma(in_color);
            prod2_reg <= prod2_next;
            luma2_reg <= luma1_reg;
            c3_reg    <= c3_next;
            gain4_reg <= gain4_next;
            c5_reg    <= c5_next;
        end
    end

    assign out_ctl   = ctl_reg[4];
    assign out_color = c5_reg;

endmodule

// ===== hdl/lcc_tft_bg.sv =====
// Background panel stage: per-channel quadratic tone curve and black threshold.
// Five register stages, aligned with the foreground stage; depends on lcc_pkg.
module lcc_tft_bg (
    input  logic              aclk,
    input  logic              en,
    input  lcc_pkg::lcc_rgb_t in_color,
    input  lcc_pkg::lcc_cfg_t cfg,
    output lcc_pkg::lcc_rgb_t out_color
);
    import lcc_pkg::*;

    lcc_rgb_t    v1_reg, v2_reg, v3_reg, v4_reg;
    logic [16:0] sq1_next [3];
    logic [16:0] sq1_reg  [3];
    lcc_rgb_t    q2_next, q2_reg;
    lcc_chan_t   inv_s;
    logic [15:0] lin3_next [3];
    logic [15:0] lin3_reg  [3];
    logic [15:0] quad3_next [3];
    logic [15:0] quad3_reg  [3];
    logic [16:0] sum4 [3];
    lcc_rgb_t    r4_next, r4_reg;
    lcc_rgb_t    c5_next, c5_reg;

    always_comb begin
        inv_s = LCC_FULL - cfg.tone_strength;
        for (int i = 0; i < 3; i++) begin
            sq1_next[i]   = 17'(in_color[i]) * 17'(in_color[i]) + 17'(LCC_HALF_RND);
            q2_next[i]    = lcc_div255(sq1_reg[i]);
            lin3_next[i]  = 16'(v2_reg[i]) * 16'(inv_s);
            quad3_next[i] = 16'(q2_reg[i]) * 16'(cfg.tone_strength);
            sum4[i]       = 17'(lin3_reg[i]) + 17'(quad3_reg[i]) + 17'(LCC_HALF_RND);
            r4_next[i]    = lcc_div255(sum4[i]);
            // end points pass through untouched
            if (v4_reg[i] == 8'd0 || v4_reg[i] == LCC_FULL) begin
                c5_next[i] = v4_reg[i];
            end else if (cfg.tone_black_cut != 8'd0 && r4_reg[i] < cfg.tone_black_cut) begin
                c5_next[i] = 8'd0;
            end else begin
                c5_next[i] = r4_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg    <= in_color;
            sq1_reg   <= sq1_next;
            v2_reg    <= v1_reg;
            q2_reg    <= q2_next;
            v3_reg    <= v2_reg;
            lin3_reg  <= lin3_next;
            quad3_reg <= quad3_next;
            v4_reg    <= v3_reg;
            r4_reg    <= r4_next;
            c5_reg    <= c5_next;
        end
    end

    assign out_color = c5_reg;

endmodule
